>>> hw/rtl/min_priority_queue_top_assert.svh
// ----------------------------------------------------------------------------
// min priority queue assertion macros
// shared concurrent assertion forms, clocked on clk and held off during rst
// ----------------------------------------------------------------------------
`ifndef MIN_PRIORITY_QUEUE_TOP_ASSERT_SVH
`define MIN_PRIORITY_QUEUE_TOP_ASSERT_SVH

// invariant checked at every clock edge
`define MPQ_ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// consequence checked in the cycle after the trigger
`define MPQ_ASSERT_NEXT(label, trig, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (expr)) \
    else $error(msg);

`endif

>>> hw/rtl/mpq_pkg.sv
// ----------------------------------------------------------------------------
// mpq_pkg
// shared widths, codes and types of the min priority queue
// ----------------------------------------------------------------------------
package mpq_pkg;

  localparam int KEY_W            = 32;
  localparam int OPCODE_W         = 2;
  localparam int STATUS_W         = 2;
  localparam int COUNT_W          = 7;
  localparam int DEFAULT_CAPACITY = 64;

  localparam logic [OPCODE_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_PEEK   = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_REMOVE = 2'd2;
  localparam logic [OPCODE_W-1:0] OP_QUERY  = 2'd3;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  // per-cycle command broadcast to every cell
  typedef struct packed {
    logic insert;
    logic remove;
  } cell_ctl_t;

  // what a cell shows its neighbors
  typedef struct packed {
    logic                    valid;
    logic                    ins_here;
    logic signed [KEY_W-1:0] key;
  } cell_link_t;

endpackage

>>> hw/rtl/mpq_in_if.sv
// ----------------------------------------------------------------------------
// mpq_in_if
// request channel: opcode and key with valid/ready
// ----------------------------------------------------------------------------
interface mpq_in_if
  import mpq_pkg::*;
();
  logic                       valid;
  logic                       ready;
  logic [OPCODE_W-1:0]        opcode;
  logic signed [KEY_W-1:0]    key_in;

  modport source (output valid, output opcode, output key_in, input ready);
  modport sink (input valid, input opcode, input key_in, output ready);
endinterface

>>> hw/rtl/mpq_out_if.sv
// ----------------------------------------------------------------------------
// mpq_out_if
// response channel: key, status and count with valid/ready
// ----------------------------------------------------------------------------
interface mpq_out_if
  import mpq_pkg::*;
();
  logic                       valid;
  logic                       ready;
  logic signed [KEY_W-1:0]    min_key;
  logic [STATUS_W-1:0]        status;
  logic [COUNT_W-1:0]         count;

  modport source (output valid, output min_key, output status, output count, input ready);
  modport sink (input valid, input min_key, input status, input count, output ready);
endinterface

>>> hw/rtl/min_priority_queue_top.sv
// ----------------------------------------------------------------------------
// min_priority_queue_top
// bounded min priority queue of signed 32-bit keys on a sorted cell chain
// ----------------------------------------------------------------------------
// request channel carries opcode and key: insert, peek, remove or size query.
// response channel returns one transfer per request: key, status, count.
// every cell compares the offered key in parallel, so an insert or a remove
// reorders the whole chain together and the minimum always sits in the
// head cell. one request is taken per cycle; the response appears in the
// output register on the next cycle.
// the single output register sets the rate: a new request is taken while the
// response register is empty or being drained in the same cycle.
// when the receiver stalls, the response holds and request ready drops.
// reset (rst, synchronous) empties the queue and clears the response valid;
// cell contents are not cleared, only their occupied flags.
// insert into a full queue reports full; peek or remove on empty reports
// empty with key zero. count is reported modulo 128.
// ----------------------------------------------------------------------------
module min_priority_queue_top
  import mpq_pkg::*;
#(
  parameter int CAPACITY = DEFAULT_CAPACITY
) (
  input logic      clk,
  input logic      rst,
  mpq_in_if.sink   request,
  mpq_out_if.source response
);

  `include "min_priority_queue_top_assert.svh"

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int XW = (CW > COUNT_W) ? CW : COUNT_W;

  logic [CW-1:0]           cnt;
  logic [CW-1:0]           cnt_next;
  logic [XW-1:0]           cnt_wide;
  logic                    full;
  logic                    empty;
  logic                    accept;
  cell_ctl_t               ctl;
  cell_link_t              head;

  logic                    res_valid;
  logic signed [KEY_W-1:0] res_key;
  logic [STATUS_W-1:0]     res_status;
  logic [COUNT_W-1:0]      res_count;
  logic signed [KEY_W-1:0] key_next;
  logic [STATUS_W-1:0]     status_next;

  assign full   = (cnt == CW'(CAPACITY));
  assign empty  = (cnt == '0);
  assign request.ready = !res_valid || response.ready;
  assign accept = request.valid && request.ready;

  always_comb begin
    ctl         = '0;
    key_next    = '0;
    status_next = ST_OK;
    cnt_next    = cnt;
    case (request.opcode)
      OP_INSERT: begin
        key_next = request.key_in;
        if (full) begin
          status_next = ST_FULL;
        end else begin
          ctl.insert = accept;
          cnt_next   = cnt + 1'b1;
        end
      end
      OP_PEEK: begin
        if (empty) begin
          status_next = ST_EMPTY;
        end else begin
          key_next = head.key;
        end
      end
      OP_REMOVE: begin
        if (empty) begin
          status_next = ST_EMPTY;
        end else begin
          key_next   = head.key;
          ctl.remove = accept;
          cnt_next   = cnt - 1'b1;
        end
      end
      default: begin
        status_next = empty ? ST_EMPTY : ST_OK;
      end
    endcase
  end

  assign cnt_wide = XW'(cnt_next);

  mpq_array #(
    .CAPACITY (CAPACITY)
  ) u_array (
    .clk     (clk),
    .rst     (rst),
    .ctl     (ctl),
    .ins_key (request.key_in),
    .head    (head)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt       <= '0;
      res_valid <= 1'b0;
    end else begin
      if (accept) begin
        cnt       <= cnt_next;
        res_valid <= 1'b1;
      end else if (response.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_key    <= key_next;
      res_status <= status_next;
      res_count  <= cnt_wide[COUNT_W-1:0];
    end
  end

  assign response.valid   = res_valid;
  assign response.min_key = res_key;
  assign response.status  = res_status;
  assign response.count   = res_count;

  `MPQ_ASSERT_ALWAYS(a_count_bound, cnt <= CW'(CAPACITY), "count above capacity")
  `MPQ_ASSERT_ALWAYS(a_head_matches_count, (cnt != '0) == head.valid, "head occupancy disagrees with count")
  `MPQ_ASSERT_NEXT(a_remove_count, accept && request.opcode == OP_REMOVE && !empty, cnt == $past(cnt) - 1'b1 && res_status == ST_OK, "remove did not shrink queue")

endmodule

>>> hw/rtl/mpq_cell.sv
// ----------------------------------------------------------------------------
// mpq_cell
// one slot of the sorted key chain; shifts right on insert, left on remove
// ----------------------------------------------------------------------------
module mpq_cell
  import mpq_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  cell_ctl_t               ctl,
  input  logic signed [KEY_W-1:0] ins_key,
  input  cell_link_t              left,
  input  cell_link_t              right,
  output cell_link_t              state
);

  logic                    valid;
  logic signed [KEY_W-1:0] key;
  logic                    ins_here;

  // new key belongs at or before this slot
  assign ins_here = !valid || (ins_key < key);

  assign state.valid    = valid;
  assign state.ins_here = ins_here;
  assign state.key      = key;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctl.insert) begin
      valid <= valid | left.valid;
    end else if (ctl.remove) begin
      valid <= right.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.insert) begin
      if (ins_here) begin
        key <= left.ins_here ? left.key : ins_key;
      end
    end else if (ctl.remove) begin
      key <= right.key;
    end
  end

endmodule

>>> hw/rtl/mpq_array.sv
// ----------------------------------------------------------------------------
// mpq_array
// chain of cells kept in ascending order, smallest key at the head
// ----------------------------------------------------------------------------
module mpq_array
  import mpq_pkg::*;
#(
  parameter int CAPACITY = DEFAULT_CAPACITY
) (
  input  logic                    clk,
  input  logic                    rst,
  input  cell_ctl_t               ctl,
  input  logic signed [KEY_W-1:0] ins_key,
  output cell_link_t              head
);

  `include "min_priority_queue_top_assert.svh"

  cell_link_t cells [CAPACITY];
  cell_link_t lefts [CAPACITY];
  cell_link_t rights[CAPACITY];

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    if (i == 0) begin : g_first
      assign lefts[i] = '{valid: 1'b1, ins_here: 1'b0, key: '0};
    end else begin : g_mid_left
      assign lefts[i] = cells[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign rights[i] = '{valid: 1'b0, ins_here: 1'b1, key: '0};
    end else begin : g_mid_right
      assign rights[i] = cells[i+1];
    end

    mpq_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .ctl     (ctl),
      .ins_key (ins_key),
      .left    (lefts[i]),
      .right   (rights[i]),
      .state   (cells[i])
    );
  end

  assign head = cells[0];

  `MPQ_ASSERT_ALWAYS(a_head_sorted, !cells[1].valid || !(cells[1].key < cells[0].key), "head pair out of order")
  `MPQ_ASSERT_ALWAYS(a_valid_prefix, !cells[1].valid || cells[0].valid, "occupied slots not contiguous")
  `MPQ_ASSERT_ALWAYS(a_no_overflow, !ctl.insert || !cells[CAPACITY-1].valid, "insert into full chain")

endmodule

>>> tb/sv/tb_min_priority_queue_top.sv
// ----------------------------------------------------------------------------
// tb_min_priority_queue_top
// self-checking bench for the min priority queue
// ----------------------------------------------------------------------------
// a short directed run covers the key extremes, each operation, the empty
// queue, tied minima and ignored keys. Random phases follow: fill, drain and
// mixed traffic, which drive the queue towards full and towards empty.
// A scoreboard keeps its own copy of the stored keys, predicts every
// response and compares key, status and count in order.
// ----------------------------------------------------------------------------
module tb_min_priority_queue_top;
  import mpq_pkg::*;

  localparam int CAPACITY     = DEFAULT_CAPACITY;
  localparam int RANDOM_ITEMS = 1200;
  localparam int IDLE_LIMIT   = 2000;
  localparam int MAX_REPORTS  = 20;

  typedef struct packed {
    logic signed [KEY_W-1:0] min_key;
    logic [STATUS_W-1:0]     status;
    logic [COUNT_W-1:0]      count;
  } queue_resp_t;

  class min_queue_scoreboard;
    logic signed [KEY_W-1:0] stored_keys[$];
    queue_resp_t             pending_responses[$];
    int                      errors;

    function new();
      errors = 0;
    endfunction

    // find the smallest stored key, the last one among equal minima
    function int min_position();
      int pos;
      pos = 0;
      for (int i = 0; i < stored_keys.size(); i++) begin
        if (stored_keys[i] <= stored_keys[pos]) pos = i;
      end
      return pos;
    endfunction

    function void note_request(logic [OPCODE_W-1:0] op, logic signed [KEY_W-1:0] key);
      queue_resp_t r;
      int          pos;
      r.min_key = '0;
      r.status  = ST_OK;
      case (op)
        OP_INSERT: begin
          r.min_key = key;
          if (stored_keys.size() >= CAPACITY) r.status = ST_FULL;
          else stored_keys = {stored_keys, key};
        end
        OP_PEEK, OP_REMOVE: begin
          if (stored_keys.size() == 0) begin
            r.status = ST_EMPTY;
          end else begin
            pos = min_position();
            r.min_key = stored_keys[pos];
            if (op == OP_REMOVE) stored_keys.delete(pos);
          end
        end
        default: begin
          r.status = (stored_keys.size() == 0) ? ST_EMPTY : ST_OK;
        end
      endcase
      r.count = COUNT_W'(stored_keys.size());
      pending_responses = {pending_responses, r};
    endfunction

    function void report(string field, longint expected, longint actual);
      errors++;
      if (errors <= MAX_REPORTS)
        $display("%0t: %s expected %0d got %0d", $time, field, expected, actual);
    endfunction

    function void check_response(logic signed [KEY_W-1:0] key, logic [STATUS_W-1:0] status,
                                 logic [COUNT_W-1:0] count);
      queue_resp_t e;
      if (pending_responses.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: unexpected response key %0d status %0d count %0d",
                   $time, key, status, count);
        return;
      end
      e = pending_responses.pop_front();
      if (key !== e.min_key) report("min_key", e.min_key, key);
      if (status !== e.status) report("status", e.status, status);
      if (count !== e.count) report("count", e.count, count);
    endfunction
  endclass

  logic clk;
  logic rst;
  bit   steady_flow;
  int   random_sent;
  int   idle_cycles;

  mpq_in_if  req_if ();
  mpq_out_if resp_if ();

  min_queue_scoreboard sb;

  min_priority_queue_top #(.CAPACITY(CAPACITY)) dut (
    .clk      (clk),
    .rst      (rst),
    .request  (req_if),
    .response (resp_if)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // transfers are seen with pre-edge values
  always @(posedge clk) begin
    if (!rst) begin
      if (resp_if.valid && resp_if.ready)
        sb.check_response(resp_if.min_key, resp_if.status, resp_if.count);
      if (req_if.valid && req_if.ready)
        sb.note_request(req_if.opcode, req_if.key_in);
    end
  end

  always @(posedge clk) begin
    if (rst || (req_if.valid && req_if.ready) || (resp_if.valid && resp_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("min_priority_queue_top test failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic int draw_gap();
    return steady_flow ? 0 : $urandom_range(0, 12);
  endfunction

  function automatic logic signed [KEY_W-1:0] pick_key();
    case ($urandom_range(0, 4))
      0: return KEY_W'($signed($urandom_range(0, 8)) - 4);
      1: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
      2: return KEY_W'($signed($urandom_range(0, 2000)) - 1000);
      default: return $urandom;
    endcase
  endfunction

  task automatic send_request(logic [OPCODE_W-1:0] op, logic signed [KEY_W-1:0] key);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_if.valid  <= 1'b1;
    req_if.opcode <= op;
    req_if.key_in <= key;
    do @(posedge clk); while (!req_if.ready);
  endtask

  // step past the current edge first so the last accepted transfer is already noted
  task automatic wait_drained();
    req_if.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending_responses.size() != 0) @(posedge clk);
  endtask

  task automatic run_phase(int kind, int length);
    int                  roll;
    logic [OPCODE_W-1:0] op;
    for (int i = 0; i < length; i++) begin
      roll = $urandom_range(0, 99);
      case (kind)
        0: op = (roll < 85) ? OP_INSERT : OPCODE_W'($urandom_range(1, 3));
        1: op = (roll < 80) ? OP_REMOVE : OPCODE_W'($urandom_range(0, 3));
        2: op = (roll < 45) ? OP_INSERT : (roll < 80) ? OP_REMOVE : OPCODE_W'($urandom_range(1, 3));
        default: op = OPCODE_W'($urandom_range(0, 3));
      endcase
      send_request(op, pick_key());
      random_sent++;
    end
  endtask

  // receiver: stall a random number of cycles before each transfer
  initial begin
    int gap;
    resp_if.ready <= 1'b0;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      gap = draw_gap();
      if (gap > 0) begin
        resp_if.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      resp_if.ready <= 1'b1;
      do @(posedge clk); while (!resp_if.valid);
    end
  end

  initial begin
    int kind;
    sb = new();
    steady_flow = 1'b0;
    random_sent = 0;
    rst = 1'b1;
    req_if.valid  <= 1'b0;
    req_if.opcode <= OP_INSERT;
    req_if.key_in <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // empty queue, extremes, tied minima, ignored keys
    send_request(OP_QUERY, 32'sh12345678);
    send_request(OP_PEEK, 32'sh7fffffff);
    send_request(OP_REMOVE, 32'sh80000000);
    send_request(OP_INSERT, 32'sh00000000);
    send_request(OP_INSERT, 32'sh7fffffff);
    send_request(OP_INSERT, 32'sh80000000);
    send_request(OP_QUERY, 32'shffffffff);
    send_request(OP_PEEK, 32'sh55555555);
    send_request(OP_REMOVE, 32'shaaaaaaaa);
    send_request(OP_INSERT, -32'sd1);
    send_request(OP_INSERT, 32'sd1);
    send_request(OP_INSERT, -32'sd1);
    send_request(OP_PEEK, '0);
    send_request(OP_REMOVE, '0);
    send_request(OP_REMOVE, '0);
    send_request(OP_REMOVE, '0);
    send_request(OP_REMOVE, '0);
    send_request(OP_PEEK, '0);
    send_request(OP_REMOVE, '0);
    send_request(OP_REMOVE, 32'sh7fffffff);
    send_request(OP_QUERY, '0);
    wait_drained();

    // first phase is an insert-heavy fill run, long enough that it can pass capacity
    kind = 0;
    while (random_sent < RANDOM_ITEMS) begin
      steady_flow = ($urandom_range(0, 3) == 0);
      run_phase(kind, (kind == 0) ? $urandom_range(70, 120) : $urandom_range(20, 120));
      if ($urandom_range(0, 3) == 0) wait_drained();
      kind = $urandom_range(0, 3);
    end
    steady_flow = 1'b0;

    wait_drained();
    repeat (5) @(posedge clk);
    if (sb.errors == 0) begin
      $display("min_priority_queue_top test passed");
    end else begin
      $display("min_priority_queue_top test failed");
    end
    $finish;
  end

endmodule
